@@ hdl/itfp_pkg.sv @@
// Shared types, constants and helpers for the IMU triple-frame parser.
package itfp_pkg;

  localparam int unsigned WinLen   = 33;
  localparam int unsigned FrameLen = 11;
  localparam int unsigned NumWords = 9;

  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;

  // Element 0 is the oldest byte, element WinLen-1 the newest.
  typedef logic [WinLen-1:0][7:0] window_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } imu_result_t;

  // Little-endian 16-bit word starting at a fixed window offset.
  function automatic logic [15:0] word_at(window_t win, int unsigned pos);
    word_at = {win[pos+1], win[pos]};
  endfunction

endpackage

@@ hdl/itfp_stream_if.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
interface itfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface itfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (
    output valid, input ready,
    output accel_x, output accel_y, output accel_z,
    output rate_x, output rate_y, output rate_z,
    output angle_x, output angle_y, output angle_z
  );
  modport sink (
    input valid, output ready,
    input accel_x, input accel_y, input accel_z,
    input rate_x, input rate_y, input rate_z,
    input angle_x, input angle_y, input angle_z
  );
endinterface

@@ hdl/itfp_window.sv @@
// Shift window holding the last 33 received bytes.
module itfp_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [7:0]        byte_i,
  output itfp_pkg::window_t win_o,
  output itfp_pkg::window_t nxt_o
);
  import itfp_pkg::*;

  window_t win_q, win_d;

  // The newest byte enters at the top and the oldest drops out at the bottom.
  assign win_d = {byte_i, win_q[WinLen-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;
  assign nxt_o = win_d;

endmodule

@@ hdl/itfp_decode.sv @@
// Frame header check and raw word extraction on the shifted window.
module itfp_decode (
  input  itfp_pkg::window_t     win_i,
  output logic                  match_o,
  output itfp_pkg::imu_result_t res_o
);
  import itfp_pkg::*;

  logic [NumWords-1:0][15:0] words;

  assign match_o = (win_i[0] == SyncByte) &&
                   (win_i[FrameLen] == SyncByte) &&
                   (win_i[2*FrameLen] == SyncByte) &&
                   (win_i[1] == TypeAccel) &&
                   (win_i[FrameLen+1] == TypeRate) &&
                   (win_i[2*FrameLen+1] == TypeAngle);

  // Three data words follow each two-byte header.
  always_comb begin
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < 3; k++) begin
        words[f*3+k] = word_at(win_i, f*FrameLen + 2 + 2*k);
      end
    end
  end

  assign res_o.accel_x = words[0];
  assign res_o.accel_y = words[1];
  assign res_o.accel_z = words[2];
  assign res_o.rate_x  = words[3];
  assign res_o.rate_y  = words[4];
  assign res_o.rate_z  = words[5];
  assign res_o.angle_x = words[6];
  assign res_o.angle_y = words[7];
  assign res_o.angle_z = words[8];

endmodule

@@ hdl/itfp_out_stage.sv @@
// Result register with valid flag, loaded when a matching window appears.
module itfp_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  itfp_pkg::imu_result_t res_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output logic                  free_o,
  output itfp_pkg::imu_result_t res_o
);
  import itfp_pkg::*;

  logic        valid_q, valid_d;
  imu_result_t res_q;

  // The register can take a new result when empty or when its content leaves now.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hdl/imu_triple_frame_parser.sv @@
// Top level of the IMU triple-frame parser.
//
//   Channel  Direction  Payload                              Per transfer
//   in_i     sink       rx_byte                              one serial byte
//   out_o    source     accel_x..z, rate_x..z, angle_x..z    nine raw 16-bit words
//
// One byte is taken every cycle unless a waiting result stalls on out_o; a result
// appears in the cycle after the byte that completes a matching window. The single
// result register lies between the window compare and the output.
// Reset clears the byte window to zeros and empties the result register.
// While a result waits on out_o, a new byte is taken only if out_o.ready is high.
module imu_triple_frame_parser (
  input  logic clk_i,
  input  logic rst_ni,
  itfp_in_if.sink    in_i,
  itfp_out_if.source out_o
);
  import itfp_pkg::*;

  logic        in_xfer;
  logic        match;
  logic        load;
  logic        free;
  window_t     win;
  window_t     nxt;
  imu_result_t dec_res;
  imu_result_t out_res;

  assign in_i.ready = free;
  assign in_xfer    = in_i.valid && free;
  assign load       = in_xfer && match;

  itfp_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_xfer),
    .byte_i  (in_i.rx_byte),
    .win_o   (win),
    .nxt_o   (nxt)
  );

  itfp_decode u_decode (
    .win_i   (nxt),
    .match_o (match),
    .res_o   (dec_res)
  );

  itfp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (dec_res),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .free_o  (free),
    .res_o   (out_res)
  );

  assign out_o.accel_x = out_res.accel_x;
  assign out_o.accel_y = out_res.accel_y;
  assign out_o.accel_z = out_res.accel_z;
  assign out_o.rate_x  = out_res.rate_x;
  assign out_o.rate_y  = out_res.rate_y;
  assign out_o.rate_z  = out_res.rate_z;
  assign out_o.angle_x = out_res.angle_x;
  assign out_o.angle_y = out_res.angle_y;
  assign out_o.angle_z = out_res.angle_z;

  // A byte that completes a matching window must give a result next cycle.
  a_match_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && match |=> out_o.valid)
    else $error("matching window did not produce a result");

  // A stalled result must block further bytes so that none is lost.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while result stalled");

  // The accepted byte lands as the newest window entry.
  a_byte_enters_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> win[WinLen-1] == $past(in_i.rx_byte))
    else $error("accepted byte missing from window");

  // The window only moves on an accepted byte.
  a_window_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(win))
    else $error("window changed without a byte transfer");

endmodule
